// ===== rtl/core/gaai_pkg.sv =====
package gaai_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int STW           = 48;
  localparam int DT_FRAC       = 16;

  localparam logic signed [63:0] MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] MIN48 = -64'sh0000_7FFF_FFFF_FFFF - 64'sd1;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_GRAV = 2'd1,
    OP_VEL  = 2'd2,
    OP_POS  = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] mass;
    logic [31:0] dt;
  } item_t;

  function automatic logic signed [63:0] sx48(input logic [STW-1:0] v);
    sx48 = $signed({{(64-STW){v[STW-1]}}, v});
  endfunction

  function automatic logic ovf48(input logic signed [63:0] v);
    ovf48 = (v > MAX48) || (v < MIN48);
  endfunction

  function automatic logic [STW-1:0] clip48(input logic signed [63:0] v);
    if (v > MAX48) begin
      clip48 = MAX48[STW-1:0];
    end else if (v < MIN48) begin
      clip48 = MIN48[STW-1:0];
    end else begin
      clip48 = v[STW-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/gaai_front.sv =====
module gaai_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [191:0]         in_data_i,
  input  logic [1:0]           in_user_i,
  output logic                 q_valid_o,
  input  logic                 q_pop_i,
  output gaai_pkg::item_t      q_item_o
);
  import gaai_pkg::*;

  // Two-entry queue of decoded items.
  item_t      mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;
  item_t      dec;

  always_comb begin
    dec.op   = op_e'(in_user_i);
    dec.px   = in_data_i[31:0];
    dec.py   = in_data_i[63:32];
    dec.vx   = in_data_i[95:64];
    dec.vy   = in_data_i[127:96];
    dec.mass = in_data_i[159:128];
    dec.dt   = in_data_i[191:160];
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= dec;
    end
  end

endmodule

// ===== rtl/core/gaai_exec.sv =====
module gaai_exec #(
  parameter int FRAC_BITS = gaai_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  gaai_pkg::item_t      q_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [287:0]         out_data_o,
  output logic [1:0]           out_user_o
);
  import gaai_pkg::*;

  localparam int DW   = (((31 + FRAC_BITS) > 47) ? (31 + FRAC_BITS) : 47) + 1;
  localparam int PW   = 2 * DW;
  localparam int D2W  = PW + 1;
  localparam int SQW  = DW + 1;
  localparam int SQN  = 2 * SQW;
  localparam int QW   = STW;
  localparam int NUMW = 32 + 3 * FRAC_BITS;
  localparam int CW   = $clog2(SQW + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_MDONE = 4'd2;
  localparam logic [3:0] S_D2    = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_DDONE = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_EACC  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]     st_q;
  logic [CW-1:0]  cnt_q;
  logic [1:0]     ph_q;
  logic           ax_q;
  op_e            op_q;
  logic [31:0]    mass_q, dt_q;
  logic           sat_q, coin_q;

  logic [STW-1:0] pos_q [2];
  logic [STW-1:0] vel_q [2];
  logic [STW-1:0] acc_q [2];

  logic [DW-1:0]  dm_q [2];
  logic [1:0]     dneg_q;
  logic [D2W-1:0] d2_q;
  logic           govf_q;
  logic [QW-1:0]  g_q;

  logic [DW-1:0]  ma_q, mb_q;
  logic [PW-1:0]  prod_q;
  logic [D2W-1:0] rem_q, dvs_q;
  logic [QW-1:0]  qsh_q;
  logic [SQN-1:0] sq_src_q;
  logic [SQW-1:0] root_q;
  logic [SQW+1:0] srem_q;

  logic           ov_q;
  logic [287:0]   od_q;
  logic [1:0]     ou_q;

  // Shared shift-add multiplier step.
  logic [PW-1:0]  prod_nx;
  assign prod_nx = {prod_q[PW-2:0], 1'b0} + (mb_q[DW-1] ? {{DW{1'b0}}, ma_q} : '0);

  // Shared restoring divider step, one quotient bit a cycle.
  logic [D2W:0]   div_t, div_s;
  logic           div_ge;
  assign div_t  = {rem_q, qsh_q[QW-1]};
  assign div_ge = div_t >= {1'b0, dvs_q};
  assign div_s  = div_t - {1'b0, dvs_q};

  // Square root step, one root bit a cycle.
  logic [SQW+3:0] sq_t, sq_tr, sq_s;
  logic           sq_ge;
  assign sq_t  = {srem_q, sq_src_q[SQN-1 -: 2]};
  assign sq_tr = {2'b00, root_q, 2'b01};
  assign sq_ge = sq_t >= sq_tr;
  assign sq_s  = sq_t - sq_tr;

  // Item decode for load and gravity.
  logic signed [63:0] ldpx, ldpy, ldvx, ldvy, dvx, dvy, ax_abs, ay_abs;
  logic [NUMW-1:0]    num;
  always_comb begin
    ldpx   = $signed({{32{q_item_i.px[31]}}, q_item_i.px}) <<< FRAC_BITS;
    ldpy   = $signed({{32{q_item_i.py[31]}}, q_item_i.py}) <<< FRAC_BITS;
    ldvx   = $signed({{32{q_item_i.vx[31]}}, q_item_i.vx}) <<< FRAC_BITS;
    ldvy   = $signed({{32{q_item_i.vy[31]}}, q_item_i.vy}) <<< FRAC_BITS;
    dvx    = ldpx - sx48(pos_q[0]);
    dvy    = ldpy - sx48(pos_q[1]);
    ax_abs = dvx[63] ? -dvx : dvx;
    ay_abs = dvy[63] ? -dvy : dvy;
    num    = {{(NUMW-32){1'b0}}, mass_q} << (3 * FRAC_BITS);
  end

  // Euler source for each axis and its magnitude.
  logic [STW-1:0] esrc0, esrc1, emag0, emag1;
  assign esrc0 = (q_item_i.op == OP_VEL) ? acc_q[0] : vel_q[0];
  assign esrc1 = (op_q == OP_VEL) ? acc_q[1] : vel_q[1];
  assign emag0 = esrc0[STW-1] ? (~esrc0 + 1'b1) : esrc0;
  assign emag1 = esrc1[STW-1] ? (~esrc1 + 1'b1) : esrc1;

  // Scaled Euler delta and sums.
  logic [PW-DT_FRAC-1:0] sc_hi;
  logic [STW:0]          sc_m;
  logic                  eneg;
  logic signed [63:0]    edelta, esum, csum, cval;
  logic [STW-1:0]        etgt, esrc_cur;
  always_comb begin
    sc_hi    = prod_q[PW-1:DT_FRAC];
    sc_m     = (sc_hi > {{(PW-DT_FRAC-STW-1){1'b0}}, 1'b1, {STW{1'b0}}})
               ? {1'b1, {STW{1'b0}}} : sc_hi[STW:0];
    esrc_cur = ax_q ? esrc1 : ((op_q == OP_VEL) ? acc_q[0] : vel_q[0]);
    eneg     = esrc_cur[STW-1];
    edelta   = eneg ? -$signed({{(63-STW){1'b0}}, sc_m}) : $signed({{(63-STW){1'b0}}, sc_m});
    etgt     = (op_q == OP_VEL) ? vel_q[ax_q] : pos_q[ax_q];
    esum     = sx48(etgt) + edelta;
    cval     = dneg_q[ax_q] ? -$signed({16'd0, qsh_q}) : $signed({16'd0, qsh_q});
    csum     = sx48(acc_q[ax_q]) + cval;
  end

  logic [QW-1:0] gq;
  logic          gsat;
  assign gsat = govf_q || qsh_q[QW-1];
  assign gq   = gsat ? MAX48[QW-1:0] : qsh_q;

  assign q_pop_o     = (st_q == S_IDLE) && q_valid_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign out_user_o  = ou_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      cnt_q    <= '0;
      ph_q     <= 2'd0;
      ax_q     <= 1'b0;
      op_q     <= OP_LOAD;
      mass_q   <= '0;
      dt_q     <= '0;
      sat_q    <= 1'b0;
      coin_q   <= 1'b0;
      pos_q[0] <= '0;
      pos_q[1] <= '0;
      vel_q[0] <= '0;
      vel_q[1] <= '0;
      acc_q[0] <= '0;
      acc_q[1] <= '0;
      dm_q[0]  <= '0;
      dm_q[1]  <= '0;
      dneg_q   <= '0;
      d2_q     <= '0;
      govf_q   <= 1'b0;
      g_q      <= '0;
      ma_q     <= '0;
      mb_q     <= '0;
      prod_q   <= '0;
      rem_q    <= '0;
      dvs_q    <= '0;
      qsh_q    <= '0;
      sq_src_q <= '0;
      root_q   <= '0;
      srem_q   <= '0;
      ov_q     <= 1'b0;
      od_q     <= '0;
      ou_q     <= '0;
    end else begin
      if (ov_q && out_ready_i && (st_q != S_OUT)) begin
        ov_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: begin
          if (q_valid_i) begin
            op_q   <= q_item_i.op;
            mass_q <= q_item_i.mass;
            dt_q   <= q_item_i.dt;
            sat_q  <= 1'b0;
            coin_q <= 1'b0;
            ax_q   <= 1'b0;
            prod_q <= '0;
            cnt_q  <= CW'(DW - 1);
            case (q_item_i.op)
              OP_LOAD: begin
                pos_q[0] <= clip48(ldpx);
                pos_q[1] <= clip48(ldpy);
                vel_q[0] <= clip48(ldvx);
                vel_q[1] <= clip48(ldvy);
                acc_q[0] <= '0;
                acc_q[1] <= '0;
                sat_q    <= ovf48(ldpx) || ovf48(ldpy) || ovf48(ldvx) || ovf48(ldvy);
                st_q     <= S_OUT;
              end
              OP_GRAV: begin
                dm_q[0] <= ax_abs[DW-1:0];
                dm_q[1] <= ay_abs[DW-1:0];
                dneg_q  <= {dvy[63], dvx[63]};
                ma_q    <= ax_abs[DW-1:0];
                mb_q    <= ax_abs[DW-1:0];
                ph_q    <= 2'd0;
                st_q    <= S_MUL;
              end
              default: begin
                ma_q <= {{(DW-STW){1'b0}}, emag0};
                mb_q <= {{(DW-32){1'b0}}, q_item_i.dt};
                st_q <= S_MUL;
              end
            endcase
          end
        end
        S_MUL: begin
          prod_q <= prod_nx;
          mb_q   <= {mb_q[DW-2:0], 1'b0};
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            st_q <= S_MDONE;
          end
        end
        S_MDONE: begin
          if (op_q == OP_GRAV) begin
            case (ph_q)
              2'd0: begin
                d2_q   <= {1'b0, prod_q};
                ma_q   <= dm_q[1];
                mb_q   <= dm_q[1];
                prod_q <= '0;
                cnt_q  <= CW'(DW - 1);
                ph_q   <= 2'd1;
                st_q   <= S_MUL;
              end
              2'd1: begin
                d2_q <= d2_q + {1'b0, prod_q};
                st_q <= S_D2;
              end
              default: begin
                rem_q <= {{(D2W-PW+QW){1'b0}}, prod_q[PW-1:QW]};
                qsh_q <= prod_q[QW-1:0];
                dvs_q <= {{(D2W-SQW){1'b0}}, root_q};
                cnt_q <= CW'(QW - 1);
                st_q  <= S_DIV;
              end
            endcase
          end else begin
            st_q <= S_EACC;
          end
        end
        S_D2: begin
          if (d2_q == '0) begin
            coin_q <= 1'b1;
            st_q   <= S_OUT;
          end else begin
            rem_q  <= {{(D2W-NUMW+QW){1'b0}}, num[NUMW-1:QW]};
            qsh_q  <= num[QW-1:0];
            dvs_q  <= d2_q;
            govf_q <= {{(D2W-NUMW+QW){1'b0}}, num[NUMW-1:QW]} >= d2_q;
            cnt_q  <= CW'(QW - 1);
            st_q   <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= div_ge ? div_s[D2W-1:0] : div_t[D2W-1:0];
          qsh_q <= {qsh_q[QW-2:0], div_ge};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            st_q <= S_DDONE;
          end
        end
        S_DDONE: begin
          if (ph_q == 2'd1) begin
            g_q      <= gq;
            sat_q    <= sat_q || gsat;
            sq_src_q <= {1'b0, d2_q};
            root_q   <= '0;
            srem_q   <= '0;
            cnt_q    <= CW'(SQW - 1);
            st_q     <= S_SQRT;
          end else begin
            acc_q[ax_q] <= clip48(csum);
            sat_q       <= sat_q || ovf48(csum);
            if (!ax_q) begin
              ax_q   <= 1'b1;
              ma_q   <= dm_q[1];
              mb_q   <= {{(DW-QW){1'b0}}, g_q};
              prod_q <= '0;
              cnt_q  <= CW'(DW - 1);
              st_q   <= S_MUL;
            end else begin
              st_q <= S_OUT;
            end
          end
        end
        S_SQRT: begin
          srem_q   <= sq_ge ? sq_s[SQW+1:0] : sq_t[SQW+1:0];
          root_q   <= {root_q[SQW-2:0], sq_ge};
          sq_src_q <= {sq_src_q[SQN-3:0], 2'b00};
          cnt_q    <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            ma_q   <= dm_q[0];
            mb_q   <= {{(DW-QW){1'b0}}, g_q};
            prod_q <= '0;
            ph_q   <= 2'd2;
            cnt_q  <= CW'(DW - 1);
            st_q   <= S_MUL;
          end
        end
        S_EACC: begin
          if (op_q == OP_VEL) begin
            vel_q[ax_q] <= clip48(esum);
          end else begin
            pos_q[ax_q] <= clip48(esum);
          end
          sat_q <= sat_q || ovf48(esum);
          if (!ax_q) begin
            ax_q   <= 1'b1;
            ma_q   <= {{(DW-STW){1'b0}}, emag1};
            mb_q   <= {{(DW-32){1'b0}}, dt_q};
            prod_q <= '0;
            cnt_q  <= CW'(DW - 1);
            st_q   <= S_MUL;
          end else begin
            st_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ov_q || out_ready_i) begin
            ov_q <= 1'b1;
            od_q <= {acc_q[1], acc_q[0], vel_q[1], vel_q[0], pos_q[1], pos_q[0]};
            ou_q <= {sat_q, coin_q};
            st_q <= S_IDLE;
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/gravity_accumulate_and_integrate.sv =====
// Single-body 2D gravity integrator in signed fixed point (48 bits, FRAC_BITS
// fraction bits). Each input transfer carries a command in tuser: load body,
// add gravity from another body, update velocity by acc*dt, or update
// position by vel*dt. Every command produces exactly one output transfer with
// the full state after the step plus the coincident and saturated flags.
// Items are queued in a two-entry input buffer, so the source may keep
// sending while one item executes, and the result sits in an output register
// while the next item starts. Items execute one at a time on a shared
// bit-serial multiplier, restoring divider and square-root unit. Taking
// W = max(31 + FRAC_BITS, 47) + 1 (48 at the default) as the multiplier width,
// a velocity or position update does two W-bit multiplies, and a gravity
// step four W-bit multiplies, three 48-bit divisions and one (W+1)-bit root.
module gravity_accumulate_and_integrate #(
  parameter int FRAC_BITS = gaai_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // pos_x, pos_y, vel_in_x, vel_in_y, body_mass, step_time (32 bits each)
  input  logic [191:0] s_axis_tdata_i,
  // cmd
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // cur_pos_x, cur_pos_y, cur_vel_x, cur_vel_y, cur_acc_x, cur_acc_y (48 each)
  output logic [287:0] m_axis_tdata_o,
  // coincident, saturated
  output logic [1:0]   m_axis_tuser_o
);
  import gaai_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // Front end: buffers and decodes incoming transfers.
  gaai_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .in_user_i  (s_axis_tuser_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  // Back end: sequencer with the arithmetic units and the body state.
  gaai_exec #(
    .FRAC_BITS (FRAC_BITS)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

  // A skipped gravity step never clips anything.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> !m_axis_tuser_o[1])
    else $error("coincident and saturated both set");

  // A result is withdrawn only after it was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(m_axis_tvalid_o) |-> $past(m_axis_tready_i))
    else $error("result dropped before transfer");

  // A full input buffer always reports a valid item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> q_valid)
    else $error("input buffer full but reports empty");

endmodule
